// File: src/tcce_pkg.sv
package tcce_pkg;

  localparam int unsigned COLUMNS  = 80;
  localparam int unsigned ROWS     = 25;
  localparam int unsigned TAB_STOP = 4;
  localparam int unsigned CELLS    = COLUMNS * ROWS;

  localparam int unsigned ColW  = 7;
  localparam int unsigned RowW  = 5;
  localparam int unsigned IdxW  = 11;
  localparam int unsigned ChrW  = 8;
  localparam int unsigned ColXW = ColW + 1;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [ChrW-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [ChrW-1:0] CH_TAB       = 8'h09;
  localparam logic [ChrW-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [ChrW-1:0] CH_FORMFEED  = 8'h0C;
  localparam logic [ChrW-1:0] CH_ESCAPE    = 8'h1B;
  localparam logic [ChrW-1:0] CH_SPACE     = 8'h20;

  typedef enum logic [2:0] {
    CMD_PUT,
    CMD_BACKSPACE,
    CMD_NEWLINE,
    CMD_FORMFEED,
    CMD_TAB,
    CMD_IGNORE,
    CMD_READ,
    CMD_READ_NONE
  } cmd_kind_e;

  typedef struct packed {
    logic            operation;
    logic [ChrW-1:0] char_code;
    logic [IdxW-1:0] cell_index;
  } in_t;

  typedef struct packed {
    logic [ColW-1:0] cursor_col;
    logic [RowW-1:0] cursor_row;
    logic [IdxW-1:0] cursor_linear;
    logic [ChrW-1:0] cell_char;
  } out_t;

  typedef struct packed {
    cmd_kind_e       kind;
    logic [ChrW-1:0] char_code;
    logic [IdxW-1:0] cell_index;
  } cmd_t;

  function automatic logic [IdxW-1:0] lin_addr(input logic [RowW-1:0] row,
                                               input logic [ColW-1:0] col);
    logic [IdxW-1:0] base;
    base = IdxW'(row) * IdxW'(COLUMNS);
    return base + IdxW'(col);
  endfunction

endpackage

// File: src/text_console_char_engine.sv
// channel  direction  payload                      handshake
// in       input      tcce_pkg::in_t  in_data_i    in_valid_i / in_ready_o
// out      output     tcce_pkg::out_t out_data_o   out_valid_o / out_ready_i
//
// a transaction passes the idle and done states, an in-range read also the read-wait state
// a scroll moves the rows up and then blanks the bottom row,
// one cell per cycle through the single write port of the cell store
// a form feed clears all 2000 cells, one per cycle
// after reset a clearing pass over all cells runs and no transaction is taken
// the command queue lets the input side keep taking transactions while the store is walked
module text_console_char_engine #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tcce_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tcce_pkg::out_t out_data_o
);
  import tcce_pkg::*;

  logic init_done;
  logic fr_valid, fr_ready;
  cmd_t fr_cmd;
  logic bk_valid, bk_ready;
  cmd_t bk_cmd;

  tcce_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (init_done),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cmd_valid_o(fr_valid),
    .cmd_ready_i(fr_ready),
    .cmd_o      (fr_cmd)
  );

  tcce_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fr_valid),
    .push_ready_o(fr_ready),
    .push_data_i (fr_cmd),
    .pop_valid_o (bk_valid),
    .pop_ready_i (bk_ready),
    .pop_data_o  (bk_cmd)
  );

  tcce_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(bk_valid),
    .cmd_ready_o(bk_ready),
    .cmd_i      (bk_cmd),
    .init_done_o(init_done),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

// File: src/tcce_ram.sv
module tcce_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/tcce_front.sv
module tcce_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tcce_pkg::in_t  in_data_i,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i,
  output tcce_pkg::cmd_t cmd_o
);
  import tcce_pkg::*;

  function automatic cmd_t classify(input in_t d);
    cmd_t c;
    c.char_code  = d.char_code;
    c.cell_index = d.cell_index;
    if (d.operation == OP_READ) begin
      c.kind = (d.cell_index < IdxW'(CELLS)) ? CMD_READ : CMD_READ_NONE;
    end else begin
      unique case (d.char_code)
        CH_ESCAPE:    c.kind = CMD_IGNORE;
        CH_BACKSPACE: c.kind = CMD_BACKSPACE;
        CH_NEWLINE:   c.kind = CMD_NEWLINE;
        CH_FORMFEED:  c.kind = CMD_FORMFEED;
        CH_TAB:       c.kind = CMD_TAB;
        default:      c.kind = CMD_PUT;
      endcase
    end
    return c;
  endfunction

  logic vld_q, vld_d;
  cmd_t cmd_q;
  logic accept;

  assign in_ready_o  = en_i && (!vld_q || cmd_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign cmd_valid_o = vld_q;
  assign cmd_o       = cmd_q;

  always_comb begin
    if (accept) begin
      vld_d = 1'b1;
    end else if (cmd_ready_i) begin
      vld_d = 1'b0;
    end else begin
      vld_d = vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= classify(in_data_i);
    end
  end

endmodule

// File: src/tcce_fifo.sv
module tcce_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  tcce_pkg::cmd_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output tcce_pkg::cmd_t pop_data_o
);
  import tcce_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = cnt_q != Full;
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: src/tcce_back.sv
module tcce_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  tcce_pkg::cmd_t cmd_i,
  output logic           init_done_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tcce_pkg::out_t out_data_o
);
  import tcce_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  localparam logic [IdxW-1:0]  LastCell    = IdxW'(CELLS - 1);
  localparam logic [IdxW-1:0]  LastRowBase = IdxW'(CELLS - COLUMNS);
  localparam logic [IdxW-1:0]  ColStep     = IdxW'(COLUMNS);
  localparam logic [ColW-1:0]  LastCol     = ColW'(COLUMNS - 1);
  localparam logic [RowW-1:0]  LastRow     = RowW'(ROWS - 1);
  localparam logic [ColXW-1:0] ColLimit    = ColXW'(COLUMNS);

  logic [2:0]      state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic [ColW-1:0] x_q, x_d;
  logic [RowW-1:0] y_q, y_d;
  logic [ChrW-1:0] cell_q, cell_d;
  logic            pend_q, pend_d;
  logic            init_q, init_d;
  logic            out_valid_q, out_valid_d;
  out_t            out_q, out_d;

  logic            we, re;
  logic [IdxW-1:0] waddr, raddr;
  logic [ChrW-1:0] wdata, rdata;

  logic [IdxW-1:0]  cur_lin, bs_lin;
  logic [ColW-1:0]  bs_x, tab_nx;
  logic [RowW-1:0]  bs_y;
  logic [ColXW-1:0] tab_x;
  logic             tab_wrap, adv_row;

  tcce_ram #(
    .WIDTH(ChrW),
    .DEPTH(CELLS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign cur_lin  = lin_addr(y_q, x_q);
  assign bs_x     = (x_q == '0) ? LastCol : x_q - 1'b1;
  assign bs_y     = (x_q == '0) ? y_q - 1'b1 : y_q;
  assign bs_lin   = lin_addr(bs_y, bs_x);
  assign tab_x    = ColXW'(((x_q / TAB_STOP) + 1) * TAB_STOP);
  assign tab_wrap = tab_x >= ColLimit;
  assign tab_nx   = tab_wrap ? ColW'(tab_x - ColLimit) : ColW'(tab_x);

  assign cmd_ready_o = state_q == S_IDLE;
  assign init_done_o = init_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    x_d         = x_q;
    y_d         = y_q;
    cell_d      = cell_q;
    pend_d      = pend_q;
    init_d      = init_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    we          = 1'b0;
    waddr       = cur_lin;
    wdata       = '0;
    re          = 1'b0;
    raddr       = cmd_i.cell_index;
    adv_row     = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_q;
        if (cnt_q == LastCell) begin
          init_d  = 1'b1;
          pend_d  = 1'b0;
          state_d = pend_q ? S_DONE : S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          cell_d  = '0;
          state_d = S_DONE;
          unique case (cmd_i.kind)
            CMD_PUT: begin
              we    = 1'b1;
              wdata = cmd_i.char_code;
              if (x_q == LastCol) begin
                x_d     = '0;
                adv_row = 1'b1;
              end else begin
                x_d = x_q + 1'b1;
              end
            end
            CMD_BACKSPACE: begin
              if (x_q != '0 || y_q != '0) begin
                x_d   = bs_x;
                y_d   = bs_y;
                we    = 1'b1;
                waddr = bs_lin;
                wdata = CH_SPACE;
              end
            end
            CMD_NEWLINE: begin
              x_d     = '0;
              adv_row = 1'b1;
            end
            CMD_FORMFEED: begin
              x_d     = '0;
              y_d     = '0;
              cnt_d   = '0;
              pend_d  = 1'b1;
              state_d = S_CLEAR;
            end
            CMD_TAB: begin
              x_d     = tab_nx;
              adv_row = tab_wrap;
            end
            CMD_IGNORE: begin
            end
            CMD_READ: begin
              re      = 1'b1;
              state_d = S_RDWAIT;
            end
            CMD_READ_NONE: begin
            end
          endcase
          if (adv_row) begin
            if (y_q == LastRow) begin
              cnt_d   = '0;
              state_d = S_SCROLL;
            end else begin
              y_d = y_q + 1'b1;
            end
          end
        end
      end
      S_RDWAIT: begin
        cell_d  = rdata;
        state_d = S_DONE;
      end
      S_SCROLL: begin
        // read one row ahead, write the previous read one cell behind
        re    = cnt_q != LastRowBase;
        raddr = cnt_q + ColStep;
        we    = cnt_q != '0;
        waddr = cnt_q - 1'b1;
        wdata = rdata;
        if (cnt_q == LastRowBase) begin
          pend_d  = 1'b1;
          state_d = S_CLEAR;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d         = 1'b1;
          out_d.cursor_col    = x_q;
          out_d.cursor_row    = y_q;
          out_d.cursor_linear = cur_lin;
          out_d.cell_char     = cell_q;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      x_q         <= '0;
      y_q         <= '0;
      pend_q      <= 1'b0;
      init_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      x_q         <= x_d;
      y_q         <= y_d;
      pend_q      <= pend_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
    out_q  <= out_d;
  end

endmodule

// File: src/tcce_checker.sv
module tcce_assert_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input tcce_pkg::out_t out_data_i
);
  import tcce_pkg::*;

  logic [7:0] open_q, open_d;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    open_d = open_q;
    if (in_acc && !out_acc) begin
      open_d = open_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      open_d = open_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> open_q != '0)
    else $error("result without an accepted transaction");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.cursor_col < ColW'(COLUMNS)
                 && out_data_i.cursor_row < RowW'(ROWS))
    else $error("cursor out of range");

  a_linear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.cursor_linear
                    == lin_addr(out_data_i.cursor_row, out_data_i.cursor_col))
    else $error("linear cursor does not match row and column");

endmodule

bind text_console_char_engine tcce_assert_checker u_tcce_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_i (in_ready_o),
  .out_valid_i(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_i (out_data_o)
);

// File: bench/tcce_checker.sv
module tcce_checker
  import tcce_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_t        out_data_i,
  output int unsigned mismatches_o,
  output int unsigned awaited_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [ChrW-1:0] screen_mem [CELLS];
  logic [ColW-1:0] col_pos;
  logic [RowW-1:0] row_pos;
  out_t            cursor_reports_q [$];
  out_t            due;
  int unsigned     mismatch_total;

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatch_total++;
    $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // scroll up by n rows, blanking what comes in at the bottom
  function automatic void shift_rows(input int unsigned n);
    if (n == 0) return;
    for (int unsigned i = 0; i < CELLS; i++) begin
      if (n < ROWS && i + n * COLUMNS < CELLS) screen_mem[i] = screen_mem[i + n * COLUMNS];
      else screen_mem[i] = '0;
    end
  endfunction

  function automatic void settle_cursor(input int unsigned x, input int unsigned y);
    if (x >= COLUMNS) begin
      y += x / COLUMNS;
      x = x % COLUMNS;
    end
    if (y >= ROWS) begin
      shift_rows(y - ROWS + 1);
      y = ROWS - 1;
    end
    col_pos = ColW'(x);
    row_pos = RowW'(y);
  endfunction

  function automatic void apply_code(input logic [ChrW-1:0] code);
    int unsigned x;
    int unsigned y;
    x = col_pos;
    y = row_pos;
    case (code)
      CH_ESCAPE: begin
      end
      CH_BACKSPACE: begin
        if (x != 0 || y != 0) begin
          if (x == 0) begin
            y--;
            x = COLUMNS - 1;
          end else begin
            x--;
          end
          screen_mem[y * COLUMNS + x] = CH_SPACE;
          col_pos = ColW'(x);
          row_pos = RowW'(y);
        end
      end
      CH_NEWLINE: begin
        settle_cursor(0, y + 1);
      end
      CH_FORMFEED: begin
        shift_rows(ROWS);
        col_pos = '0;
        row_pos = '0;
      end
      CH_TAB: begin
        settle_cursor((x / TAB_STOP + 1) * TAB_STOP, y);
      end
      default: begin
        screen_mem[y * COLUMNS + x] = code;
        settle_cursor(x + 1, y);
      end
    endcase
  endfunction

  function automatic out_t console_step(input in_t item);
    out_t r;
    r.cell_char = '0;
    if (item.operation == OP_PUT) begin
      apply_code(item.char_code);
    end else if (item.cell_index < CELLS) begin
      r.cell_char = screen_mem[item.cell_index];
    end
    r.cursor_col    = col_pos;
    r.cursor_row    = row_pos;
    r.cursor_linear = IdxW'(row_pos * COLUMNS + col_pos);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_rows(ROWS);
      col_pos = '0;
      row_pos = '0;
      cursor_reports_q.delete();
      mismatch_total = 0;
      mismatches_o <= 0;
      awaited_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (cursor_reports_q.size() == 0) begin
          report_mismatch("result with no transaction pending", out_data_i, 0);
        end else begin
          due = cursor_reports_q.pop_front();
          if (out_data_i.cursor_col !== due.cursor_col)
            report_mismatch("cursor_col", out_data_i.cursor_col, due.cursor_col);
          if (out_data_i.cursor_row !== due.cursor_row)
            report_mismatch("cursor_row", out_data_i.cursor_row, due.cursor_row);
          if (out_data_i.cursor_linear !== due.cursor_linear)
            report_mismatch("cursor_linear", out_data_i.cursor_linear, due.cursor_linear);
          if (out_data_i.cell_char !== due.cell_char)
            report_mismatch("cell_char", out_data_i.cell_char, due.cell_char);
        end
      end
      if (in_valid_i && in_ready_i) begin
        cursor_reports_q.push_back(console_step(in_data_i));
      end
      mismatches_o <= mismatch_total;
      awaited_o    <= cursor_reports_q.size();
    end
  end

endmodule

// File: bench/tb_text_console_char_engine.sv
module tb_text_console_char_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import tcce_pkg::*;

  localparam int unsigned CycleLimit  = 20_000_000;
  localparam int unsigned RandomItems = 1950;
  localparam int unsigned SettleWait  = 2100;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  int unsigned mismatches;
  int unsigned awaited;
  int unsigned items_sent;
  int unsigned cycles;

  text_console_char_engine uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  tcce_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .mismatches_o(mismatches),
    .awaited_o   (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("text_console_char_engine regression: fail");
      $finish;
    end
  end

  function automatic bit is_control(input logic [ChrW-1:0] code);
    return code == CH_BACKSPACE || code == CH_TAB || code == CH_NEWLINE ||
           code == CH_FORMFEED || code == CH_ESCAPE;
  endfunction

  function automatic logic [ChrW-1:0] printable_code();
    logic [ChrW-1:0] c;
    do c = ChrW'($urandom_range(255, 0));
    while (is_control(c));
    return c;
  endfunction

  function automatic in_t put_item(input logic [ChrW-1:0] code);
    in_t t;
    t.operation  = OP_PUT;
    t.char_code  = code;
    t.cell_index = IdxW'($urandom_range(2047, 0));
    return t;
  endfunction

  function automatic in_t read_item(input int unsigned idx);
    in_t t;
    t.operation  = OP_READ;
    t.char_code  = ChrW'($urandom_range(255, 0));
    t.cell_index = IdxW'(idx);
    return t;
  endfunction

  function automatic in_t noise_item();
    in_t t;
    t.operation  = logic'($urandom_range(1, 0));
    t.char_code  = ChrW'($urandom_range(255, 0));
    t.cell_index = IdxW'($urandom_range(2047, 0));
    return t;
  endfunction

  // valid is left high after acceptance, lowered only when a gap follows or on drain
  task automatic send_item(input in_t item);
    int unsigned gap;
    gap = 0;
    if (!(items_sent >= 1000 && items_sent < 1300)) begin
      while ($urandom_range(99, 0) < 21) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk);
    while (awaited != 0);
  endtask

  // receiver: random stalls, one long hold-off, one stretch always ready
  initial begin
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!held && items_sent >= 300) begin
        held      = 1'b1;
        hold_left = 700;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (items_sent >= 1000 && items_sent < 1300) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99, 0) >= 21);
      end
    end
  end

  initial begin
    in_t         plan [$];
    int unsigned pick;
    int unsigned idx;
    bit          drained;
    in_valid   = 1'b0;
    in_data    = '0;
    items_sent = 0;
    drained    = 1'b0;
    @(posedge rst_n);

    plan.push_back(read_item(0));
    plan.push_back(read_item(CELLS - 1));
    plan.push_back(read_item(CELLS));
    plan.push_back(read_item(2047));
    plan.push_back(put_item(CH_BACKSPACE));      // backspace at origin
    plan.push_back(put_item(8'h00));
    plan.push_back(put_item(8'hFF));
    plan.push_back(put_item(8'h41));
    plan.push_back(put_item(CH_BACKSPACE));
    plan.push_back(put_item(CH_TAB));
    plan.push_back(put_item(CH_ESCAPE));
    plan.push_back(put_item(CH_NEWLINE));
    plan.push_back(put_item(CH_BACKSPACE));      // back across the row edge
    plan.push_back(put_item(8'h7E));             // last column, wraps
    plan.push_back(put_item(CH_BACKSPACE));
    plan.push_back(put_item(CH_TAB));            // tab past the row end
    plan.push_back(read_item(0));
    plan.push_back(read_item(1));
    plan.push_back(read_item(COLUMNS - 1));
    plan.push_back(put_item(CH_FORMFEED));
    plan.push_back(read_item(1));
    plan.push_back(put_item(8'h80));
    plan.push_back(put_item(8'h55));
    foreach (plan[i]) send_item(plan[i]);
    drain();

    while (items_sent < RandomItems + plan.size()) begin
      if (!drained && items_sent >= 700) begin
        drain();
        drained = 1'b1;
      end
      pick = $urandom_range(99, 0);
      if (pick < 40) begin
        repeat ($urandom_range(40, 1)) send_item(put_item(printable_code()));
        if ($urandom_range(1, 0)) send_item(put_item(CH_NEWLINE));
      end else if (pick < 55) begin
        repeat ($urandom_range(6, 1)) begin
          if ($urandom_range(1, 0)) idx = $urandom_range(2047, 0);
          else idx = $urandom_range(CELLS - 1, CELLS - 6 * COLUMNS);
          send_item(read_item(idx));
        end
      end else if (pick < 65) begin
        repeat ($urandom_range(5, 1)) send_item(put_item(CH_BACKSPACE));
      end else if (pick < 73) begin
        repeat ($urandom_range(4, 1)) send_item(put_item(CH_TAB));
      end else if (pick < 78) begin
        repeat ($urandom_range(6, 1)) send_item(put_item(CH_NEWLINE));
      end else if (pick < 81) begin
        send_item(put_item(CH_FORMFEED));
      end else begin
        repeat ($urandom_range(4, 1)) send_item(noise_item());
      end
    end

    drain();
    repeat (SettleWait) @(posedge clk);
    if (mismatches == 0) begin
      $display("text_console_char_engine regression: pass");
    end else begin
      $display("text_console_char_engine regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/tcce_pkg.sv
src/tcce_ram.sv
src/tcce_front.sv
src/tcce_fifo.sv
src/tcce_back.sv
src/text_console_char_engine.sv
src/tcce_checker.sv
bench/tcce_checker.sv
bench/tb_text_console_char_engine.sv
